// ===== hw/rtl/tsq_pkg.sv =====
// tsq_pkg: shared sizes, field types and codes of the two-stack queue
// no dependencies; imported by the interfaces, the top level and the testbench
package tsq_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int DATA_W      = 32;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic [1:0]               status_t;

  // operation codes of the mode field
  localparam logic MODE_ENQ = 1'b0;
  localparam logic MODE_DEQ = 1'b1;

  // result status codes
  localparam status_t ST_DONE  = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;

endpackage

// ===== hw/rtl/tsq_if.sv =====
// tsq_in_if / tsq_out_if: valid-ready channels of the two-stack queue
// depends on tsq_pkg for the payload types
interface tsq_in_if;
  import tsq_pkg::*;
  logic  valid;
  logic  ready;
  logic  mode;
  data_t enqueue_value;

  modport source (output valid, output mode, output enqueue_value, input ready);
  modport sink   (input valid, input mode, input enqueue_value, output ready);
endinterface

interface tsq_out_if;
  import tsq_pkg::*;
  logic    valid;
  logic    ready;
  status_t status;
  data_t   dequeued_value;
  logic    queue_empty;

  modport source (output valid, output status, output dequeued_value, output queue_empty,
                  input ready);
  modport sink   (input valid, input status, input dequeued_value, input queue_empty,
                  output ready);
endinterface

// ===== hw/rtl/tsq_ram.sv =====
// tsq_ram: simple dual-port synchronous ram, one write and one read port
// read data registered, held until the next read; no package dependency
module tsq_ram #(
  parameter int DEPTH  = 16,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/two_stack_queue.sv =====
// two_stack_queue: fifo built from an inbound and an outbound stack in two rams
// depends on tsq_pkg, tsq_in_if / tsq_out_if and tsq_ram
//
//  channel | dir | handshake       | payload
//  in_ch   | in  | valid / ready   | mode, enqueue_value
//  out_ch  | out | valid / ready   | status, dequeued_value, queue_empty
//
// a plain enqueue, a full or empty status and a dequeue from a non-empty
// outbound stack: accepted in idle, then the result is loaded in the finish state
// a move of n entries across issues one inbound ram read per cycle; the registered
// read data goes to the outbound ram, but a dequeue's bottom entry is the result
// synchronous active-low reset empties both stacks; the ram contents are not cleared
// a stalled result sits in the output register while the next item is taken;
// that item's result waits in the finish state until the register frees up
module two_stack_queue (
  input logic       clk,
  input logic       rst_n,
  tsq_in_if.sink    in_ch,
  tsq_out_if.source out_ch
);
  import tsq_pkg::*;

  // control states
  localparam logic [1:0] S_IDLE = 2'd0;  // waiting for an item
  localparam logic [1:0] S_MOVE = 2'd1;  // moving inbound entries across
  localparam logic [1:0] S_FIN  = 2'd2;  // result ready for the output register

  // where the result value comes from
  localparam logic [1:0] SRC_ZERO = 2'd0;
  localparam logic [1:0] SRC_OUT  = 2'd1;  // outbound ram read data (plain pop)
  localparam logic [1:0] SRC_IN   = 2'd2;  // inbound ram read data (last moved entry)

  logic [1:0] state_r, state_nxt;
  cnt_t       in_cnt_r, in_cnt_nxt;
  cnt_t       out_cnt_r, out_cnt_nxt;
  logic       mv_v_r, mv_v_nxt;        // inbound read data valid this cycle
  logic       mv_last_r, mv_last_nxt;  // that read was the bottom entry
  logic       op_deq_r, op_deq_nxt;
  data_t      hold_val_r, hold_val_nxt;
  status_t    res_status_r, res_status_nxt;
  logic [1:0] res_src_r, res_src_nxt;

  logic       out_valid_r, out_valid_nxt;
  status_t    out_status_r, out_status_nxt;
  data_t      out_value_r, out_value_nxt;
  logic       out_empty_r, out_empty_nxt;

  // ram ports
  logic  in_we, in_re, out_we, out_re;
  addr_t in_waddr, in_raddr, out_waddr, out_raddr;
  data_t in_wdata, out_wdata;
  logic [DATA_W-1:0] in_rdata_raw, out_rdata_raw;
  data_t in_rdata, out_rdata;

  cnt_t  in_top, out_top;  // count minus one, the top-of-stack index
  logic  accept;
  logic  out_free;
  data_t res_value;

  assign in_top    = in_cnt_r - cnt_t'(1);
  assign out_top   = out_cnt_r - cnt_t'(1);
  assign in_rdata  = data_t'(in_rdata_raw);
  assign out_rdata = data_t'(out_rdata_raw);

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  always_comb begin
    case (res_src_r)
      SRC_OUT: res_value = out_rdata;
      SRC_IN:  res_value = in_rdata;
      default: res_value = '0;
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    in_cnt_nxt     = in_cnt_r;
    out_cnt_nxt    = out_cnt_r;
    mv_v_nxt       = mv_v_r;
    mv_last_nxt    = mv_last_r;
    op_deq_nxt     = op_deq_r;
    hold_val_nxt   = hold_val_r;
    res_status_nxt = res_status_r;
    res_src_nxt    = res_src_r;

    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_empty_nxt  = out_empty_r;

    in_we     = 1'b0;
    in_waddr  = in_cnt_r[ADDR_W-1:0];
    in_wdata  = in_ch.enqueue_value;
    in_re     = 1'b0;
    in_raddr  = in_top[ADDR_W-1:0];
    out_we    = 1'b0;
    out_waddr = out_cnt_r[ADDR_W-1:0];
    out_wdata = in_rdata;
    out_re    = 1'b0;
    out_raddr = out_top[ADDR_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_status_nxt = ST_DONE;
          res_src_nxt    = SRC_ZERO;
          state_nxt      = S_FIN;
          if (in_ch.mode == MODE_ENQ) begin
            if (in_cnt_r != cnt_t'(STACK_DEPTH)) begin
              // room on the inbound stack: push
              in_we      = 1'b1;
              in_cnt_nxt = in_cnt_r + cnt_t'(1);
            end else if (out_cnt_r != '0) begin
              res_status_nxt = ST_FULL;
            end else begin
              // inbound full, outbound empty: move across, then push
              op_deq_nxt   = 1'b0;
              hold_val_nxt = in_ch.enqueue_value;
              state_nxt    = S_MOVE;
            end
          end else begin
            if (out_cnt_r != '0) begin
              // pop, data arrives next cycle
              out_re      = 1'b1;
              out_cnt_nxt = out_top;
              res_src_nxt = SRC_OUT;
            end else if (in_cnt_r == '0) begin
              res_status_nxt = ST_EMPTY;
            end else begin
              op_deq_nxt = 1'b1;
              state_nxt  = S_MOVE;
            end
          end
        end
      end

      S_MOVE: begin
        // issue one inbound read per cycle, top first
        if (in_cnt_r != '0) begin
          in_re       = 1'b1;
          in_cnt_nxt  = in_top;
          mv_v_nxt    = 1'b1;
          mv_last_nxt = (in_cnt_r == cnt_t'(1));
        end else begin
          mv_v_nxt    = 1'b0;
          mv_last_nxt = 1'b0;
        end
        // land the previous read on the outbound stack
        if (mv_v_r) begin
          if (mv_last_r && op_deq_r) begin
            // the bottom inbound entry is the element dequeued, never stored
            res_status_nxt = ST_DONE;
            res_src_nxt    = SRC_IN;
            state_nxt      = S_FIN;
          end else begin
            out_we      = 1'b1;
            out_cnt_nxt = out_cnt_r + cnt_t'(1);
            if (mv_last_r) begin
              // inbound now empty: push the held value at the bottom
              in_we          = 1'b1;
              in_waddr       = '0;
              in_wdata       = hold_val_r;
              in_cnt_nxt     = cnt_t'(1);
              res_status_nxt = ST_DONE;
              res_src_nxt    = SRC_ZERO;
              state_nxt      = S_FIN;
            end
          end
        end
      end

      S_FIN: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_value_nxt  = res_value;
          out_empty_nxt  = (in_cnt_r == '0) && (out_cnt_r == '0);
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_cnt_r    <= '0;
      out_cnt_r   <= '0;
      mv_v_r      <= 1'b0;
      mv_last_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_cnt_r    <= in_cnt_nxt;
      out_cnt_r   <= out_cnt_nxt;
      mv_v_r      <= mv_v_nxt;
      mv_last_r   <= mv_last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    op_deq_r     <= op_deq_nxt;
    hold_val_r   <= hold_val_nxt;
    res_status_r <= res_status_nxt;
    res_src_r    <= res_src_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_empty_r  <= out_empty_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.dequeued_value = out_value_r;
  assign out_ch.queue_empty    = out_empty_r;

  // inbound stack storage
  tsq_ram #(
    .DEPTH  (STACK_DEPTH),
    .WIDTH  (DATA_W),
    .ADDR_W (ADDR_W)
  ) u_in_ram (
    .clk   (clk),
    .we    (in_we),
    .waddr (in_waddr),
    .wdata (in_wdata),
    .re    (in_re),
    .raddr (in_raddr),
    .rdata (in_rdata_raw)
  );

  // outbound stack storage
  tsq_ram #(
    .DEPTH  (STACK_DEPTH),
    .WIDTH  (DATA_W),
    .ADDR_W (ADDR_W)
  ) u_out_ram (
    .clk   (clk),
    .we    (out_we),
    .waddr (out_waddr),
    .wdata (out_wdata),
    .re    (out_re),
    .raddr (out_raddr),
    .rdata (out_rdata_raw)
  );

  // the two stacks together never hold more than one stack's worth during a move
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOVE) |->
      ({1'b0, in_cnt_r} + {1'b0, out_cnt_r} <= (CNT_W + 1)'(STACK_DEPTH)))
    else $error("stack counts exceed depth during move");

  // a full status only when inbound is full and outbound is not empty
  a_full_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && res_status_r == ST_FULL) |->
      (in_cnt_r == cnt_t'(STACK_DEPTH) && out_cnt_r != '0))
    else $error("full status with room left");

  // an empty status only when both stacks are empty
  a_empty_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && res_status_r == ST_EMPTY) |->
      (in_cnt_r == '0 && out_cnt_r == '0))
    else $error("empty status with entries stored");

  // a move only starts on an empty outbound stack
  a_move_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && state_nxt == S_MOVE) |-> (out_cnt_r == '0 && !mv_v_r))
    else $error("move started with outbound entries");

  // a stalled result is never overwritten
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> (out_valid_r && $stable(out_value_r)))
    else $error("stalled result overwritten");

endmodule

// ===== sim/two_stack_queue_tb.sv =====
`timescale 1ns / 100ps
// two_stack_queue_tb: self-checking bench for the two-stack fifo
// drives random and directed items and checks every result against its own fifo model
// depends on tsq_pkg, tsq_in_if / tsq_out_if and the two_stack_queue rtl
module two_stack_queue_tb;
  import tsq_pkg::*;

  // one expected result item, field for field
  typedef struct packed {
    status_t status;
    data_t   dequeued_value;
    logic    queue_empty;
  } queue_result_t;

  // drain margin covering a full move across plus the result load
  localparam int DRAIN_CYCLES = 2 * STACK_DEPTH + 8;

  logic clk;
  logic rst_n;

  tsq_in_if  in_ch();
  tsq_out_if out_ch();

  two_stack_queue dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // fifo model: two bounded stacks, same shape as the block
  data_t lifo_in  [STACK_DEPTH];
  data_t lifo_out [STACK_DEPTH];
  int    lifo_in_fill;
  int    lifo_out_fill;

  queue_result_t pending_results[$];
  int            fail_count;

  // pacing knobs, percent of cycles
  int src_idle_pct;
  int snk_stall_pct;
  // long receiver hold-off, picked up and counted by the receiver process
  int ready_hold_req;

  // clock, 2 ns period
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // global watchdog, far beyond the slowest correct run
  initial begin
    #2000000;
    $display("FAIL two_stack_queue");
    $finish;
  end

  // pop the whole inbound stack onto the outbound one, reversing the order
  function automatic void reverse_into_out();
    while (lifo_in_fill > 0 && lifo_out_fill < STACK_DEPTH) begin
      lifo_in_fill--;
      lifo_out[lifo_out_fill] = lifo_in[lifo_in_fill];
      lifo_out_fill++;
    end
  endfunction

  // apply one operation to the model and return the result it must produce
  function automatic queue_result_t model_queue_op(input logic mode, input data_t value);
    queue_result_t r;
    r.status         = ST_DONE;
    r.dequeued_value = '0;
    if (mode == MODE_ENQ) begin
      // inbound full: move across if the outbound side is empty, else report full
      if (lifo_in_fill >= STACK_DEPTH) begin
        if (lifo_out_fill == 0) begin
          reverse_into_out();
        end else begin
          r.status = ST_FULL;
        end
      end
      if (r.status == ST_DONE && lifo_in_fill < STACK_DEPTH) begin
        lifo_in[lifo_in_fill] = value;
        lifo_in_fill++;
      end
    end else begin
      // outbound empty: refill it from the inbound side first
      if (lifo_out_fill == 0) begin
        reverse_into_out();
      end
      if (lifo_out_fill == 0) begin
        r.status = ST_EMPTY;
      end else begin
        lifo_out_fill--;
        r.dequeued_value = lifo_out[lifo_out_fill];
      end
    end
    r.queue_empty = (lifo_in_fill == 0 && lifo_out_fill == 0);
    return r;
  endfunction

  // data word with the extremes showing up often
  function automatic data_t rand_word();
    data_t w;
    case ($urandom_range(7))
      0:       w = 32'sh7fff_ffff;
      1:       w = 32'sh8000_0000;
      2:       w = '0;
      3:       w = -32'sd1;
      default: w = $urandom;
    endcase
    return w;
  endfunction

  // offer one item from the falling edge and wait for it to be taken;
  // valid stays high afterwards so back-to-back items need no gap
  task automatic send_item(input logic mode, input data_t value);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.mode          <= mode;
    in_ch.enqueue_value <= value;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    // taken at this edge: the model advances in acceptance order
    pending_results.push_back(model_queue_op(mode, value));
  endtask

  // stop offering, wait for every outstanding result, then let the block settle
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // receiver: random stalls, or a long hold-off when one is requested
  initial begin
    int hold_left;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (ready_hold_req > 0) begin
        hold_left      = ready_hold_req;
        ready_hold_req = 0;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  // result checker: every taken result against the oldest expectation
  always @(posedge clk) begin
    queue_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result item with nothing expected: status %0d value %0d empty %0d",
               out_ch.status, out_ch.dequeued_value, out_ch.queue_empty);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_ch.status !== want.status) begin
          $error("status expected %0d actual %0d", want.status, out_ch.status);
          fail_count++;
        end
        if (out_ch.dequeued_value !== want.dequeued_value) begin
          $error("dequeued_value expected %0d actual %0d",
                 want.dequeued_value, out_ch.dequeued_value);
          fail_count++;
        end
        if (out_ch.queue_empty !== want.queue_empty) begin
          $error("queue_empty expected %0d actual %0d", want.queue_empty, out_ch.queue_empty);
          fail_count++;
        end
      end
    end
  end

  // dequeue right after reset: empty status, nothing changes
  task automatic test_dequeue_empty();
    send_item(MODE_DEQ, 32'sh1234_5678);
    drain_results();
  endtask

  // fill the inbound stack with the extremes, then one more enqueue forces the
  // move across before the push; dequeues then return the oldest items
  task automatic test_fill_and_move();
    data_t v;
    for (int i = 0; i < STACK_DEPTH; i++) begin
      case (i)
        0:       v = 32'sh7fff_ffff;
        1:       v = 32'sh8000_0000;
        2:       v = '0;
        3:       v = -32'sd1;
        4:       v = 32'sh5555_5555;
        5:       v = 32'shaaaa_aaaa;
        default: v = $urandom;
      endcase
      send_item(MODE_ENQ, v);
    end
    send_item(MODE_ENQ, 32'sh0000_0001);
    send_item(MODE_DEQ, '0);
    send_item(MODE_DEQ, 32'shffff_ffff);
    drain_results();
  endtask

  // receiver holds off for a long stretch while enqueues keep coming, so the
  // block backs up onto its input; the stacks also run into the full status
  task automatic test_backpressure();
    snk_stall_pct  = 0;
    src_idle_pct   = 0;
    ready_hold_req = 300;
    repeat (40) send_item(MODE_ENQ, rand_word());
    // empty it again, running into the empty status at the end
    repeat (40) send_item(MODE_DEQ, rand_word());
    drain_results();
  endtask

  // random traffic in bursts with a drifting enqueue bias, so the fill level
  // swings between empty and full and every move and status case is reached
  task automatic test_random_phase(input int idle_pct, input int stall_pct, input int n_items);
    int enq_bias;
    int burst;
    int sent;
    src_idle_pct  = idle_pct;
    snk_stall_pct = stall_pct;
    sent          = 0;
    while (sent < n_items) begin
      case ($urandom_range(3))
        0:       enq_bias = 90;
        1:       enq_bias = 15;
        2:       enq_bias = 60;
        default: enq_bias = 40;
      endcase
      burst = $urandom_range(40, 8);
      repeat (burst) begin
        send_item(($urandom_range(99) < enq_bias) ? MODE_ENQ : MODE_DEQ, rand_word());
        sent++;
      end
    end
    drain_results();
  endtask

  initial begin
    // every block input known from time zero
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.mode          = MODE_ENQ;
    in_ch.enqueue_value = '0;
    src_idle_pct        = 0;
    snk_stall_pct       = 0;
    ready_hold_req      = 0;
    fail_count          = 0;
    lifo_in_fill        = 0;
    lifo_out_fill       = 0;

    // synchronous reset, released between edges
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_dequeue_empty();
    test_fill_and_move();
    test_backpressure();
    test_random_phase(0, 0, 400);
    test_random_phase(72, 0, 400);
    test_random_phase(0, 72, 400);
    test_random_phase(21, 21, 400);

    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("PASS two_stack_queue");
    end else begin
      $display("FAIL two_stack_queue");
    end
    $finish;
  end

endmodule
